// ===== design/lrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and codes for the labelled region statistics block.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int LABEL_W = 16;
    localparam int COORD_W = 9;
    localparam int COUNT_W = 28;
    localparam int SUM_W   = 37;
    localparam int CENT_W  = 17;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        K_ACC,
        K_READ,
        K_CLEAR,
        K_NOP
    } kind_t;

    // classified item passed from front to back
    typedef struct packed {
        kind_t                        kind;
        logic [STAT_W-1:0]            status;
        logic [LABEL_W-1:0]           label;
        logic [2:0][COORD_W-1:0]      pos;
    } item_t;

    // one table entry
    typedef struct packed {
        logic [COUNT_W-1:0]           count;
        logic [2:0][SUM_W-1:0]        sum;
        logic [2:0][COORD_W-1:0]      lo;
        logic [2:0][COORD_W-1:0]      hi;
    } entry_t;

endpackage

// ===== design/labelled_region_statistics_top.sv =====
// ----------------------------------------------------------------------------
// labelled_region_statistics_top
// Per-region voxel count, bounding box and centroid over a labelled volume.
// ----------------------------------------------------------------------------
// One beat in, one result beat out, in order. With the back end idle, an
// accumulate result is presented after the queue pop with table read and
// then the update write with result register; a read result after the pop,
// the divider load and the centroid divider working one quotient bit per
// cycle on all three axes at once; a clear result after the pop and a sweep
// that writes one table entry per cycle. After reset the same sweep runs
// over all NUM_REGIONS entries before the first beat reaches the table;
// the two-beat input queue still takes beats meanwhile. Items are processed
// one at a time; the next leaves the queue the cycle after the previous
// result beat has gone. Centroid is sum*256/count, truncated, 8 fraction bits.
module labelled_region_statistics_top
    import lrs_pkg::*;
#(
    parameter int NUM_REGIONS = 1024,
    parameter int MAX_DIM     = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [LABEL_W-1:0] label,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] pos_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [STAT_W-1:0]  status,
    output logic [COUNT_W-1:0] voxel_count,
    output logic [COORD_W-1:0] min_x,
    output logic [COORD_W-1:0] min_y,
    output logic [COORD_W-1:0] min_z,
    output logic [COORD_W-1:0] max_x,
    output logic [COORD_W-1:0] max_y,
    output logic [COORD_W-1:0] max_z,
    output logic [CENT_W-1:0]  centroid_x,
    output logic [CENT_W-1:0]  centroid_y,
    output logic [CENT_W-1:0]  centroid_z
);

    logic                     q_valid;
    item_t                    q_item;
    logic                     q_pop;
    logic [2:0][COORD_W-1:0]  box_lo, box_hi;
    logic [2:0][CENT_W-1:0]   cent;

    // front: classify and queue
    lrs_front #(
        .NUM_REGIONS (NUM_REGIONS),
        .MAX_DIM     (MAX_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .label    (label),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: table, divider, result register
    lrs_back #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .voxel_count (voxel_count),
        .box_lo      (box_lo),
        .box_hi      (box_hi),
        .cent        (cent)
    );

    assign min_x      = box_lo[0];
    assign min_y      = box_lo[1];
    assign min_z      = box_lo[2];
    assign max_x      = box_hi[0];
    assign max_y      = box_hi[1];
    assign max_z      = box_hi[2];
    assign centroid_x = cent[0];
    assign centroid_y = cent[1];
    assign centroid_z = cent[2];

endmodule

// ===== design/lrs_front.sv =====
// ----------------------------------------------------------------------------
// lrs_front
// Accepts command beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lrs_front
    import lrs_pkg::*;
#(
    parameter int NUM_REGIONS = 1024,
    parameter int MAX_DIM     = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [LABEL_W-1:0] label,
    input  logic [COORD_W-1:0] pos_x,
    input  logic [COORD_W-1:0] pos_y,
    input  logic [COORD_W-1:0] pos_z,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    item_t       cls;
    logic        push;
    logic        in_range;

    function automatic logic [COORD_W-1:0] sat(input logic [COORD_W-1:0] v);
        if (int'(v) > MAX_DIM - 1)
            return COORD_W'(MAX_DIM - 1);
        return v;
    endfunction

    assign in_range = (label != '0) && (int'(label) <= NUM_REGIONS);

    always_comb
    begin
        cls.label  = label;
        cls.pos[0] = sat(pos_x);
        cls.pos[1] = sat(pos_y);
        cls.pos[2] = sat(pos_z);
        cls.status = ST_OK;
        cls.kind   = K_NOP;
        unique case (command)
            CMD_ACC:
            begin
                if (label == '0)
                    cls.kind = K_NOP;
                else if (!in_range)
                    cls.status = ST_RANGE;
                else
                    cls.kind = K_ACC;
            end
            CMD_READ:
            begin
                if (in_range)
                    cls.kind = K_READ;
                else
                    cls.status = ST_RANGE;
            end
            CMD_CLEAR: cls.kind = K_CLEAR;
            default:   cls.kind = K_NOP;
        endcase
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== design/lrs_back.sv =====
// ----------------------------------------------------------------------------
// lrs_back
// Table memory, read-modify-write, clear sweep, centroid divider, result reg.
// ----------------------------------------------------------------------------
module lrs_back
    import lrs_pkg::*;
#(
    parameter int NUM_REGIONS = 1024
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  item_t                     q_item,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STAT_W-1:0]         status,
    output logic [COUNT_W-1:0]        voxel_count,
    output logic [2:0][COORD_W-1:0]   box_lo,
    output logic [2:0][COORD_W-1:0]   box_hi,
    output logic [2:0][CENT_W-1:0]    cent
);

    localparam int AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int DIV_STEPS = CENT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_OUT
    } state_t;

    entry_t mem [NUM_REGIONS];
    entry_t rdata_reg;

    state_t                       state_reg;
    logic [AW-1:0]                clr_addr_reg;
    logic                         clr_reply_reg;
    item_t                        cur_reg;
    logic [4:0]                   step_reg;
    logic [2:0][COUNT_W-1:0]      rem_reg;
    logic [2:0][CENT_W-1:0]       quo_reg;
    logic                         out_valid_reg;
    logic [STAT_W-1:0]            status_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [2:0][COORD_W-1:0]      lo_reg, hi_reg;

    logic [AW-1:0]                rd_addr, cur_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    entry_t                       wr_data, upd;
    logic [2:0][COUNT_W:0]        trial;
    logic [2:0]                   fits;

    assign rd_addr  = AW'(q_item.label - LABEL_W'(1));
    assign cur_addr = AW'(cur_reg.label - LABEL_W'(1));
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // accumulate update of the entry just read
    always_comb
    begin
        upd       = rdata_reg;
        upd.count = rdata_reg.count + COUNT_W'(1);
        for (int a = 0; a < 3; a++)
        begin
            upd.sum[a] = rdata_reg.sum[a] + SUM_W'(cur_reg.pos[a]);
            if (rdata_reg.count == '0)
            begin
                upd.lo[a] = cur_reg.pos[a];
                upd.hi[a] = cur_reg.pos[a];
            end
            else
            begin
                upd.lo[a] = (cur_reg.pos[a] < rdata_reg.lo[a]) ? cur_reg.pos[a]
                                                                  : rdata_reg.lo[a];
                upd.hi[a] = (cur_reg.pos[a] > rdata_reg.hi[a]) ? cur_reg.pos[a]
                                                                  : rdata_reg.hi[a];
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = upd;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == S_EXEC && cur_reg.kind == K_ACC && rdata_reg.count != '1)
            wr_en = 1'b1;
    end

    // one restoring step per axis
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            trial[a] = {rem_reg[a], quo_reg[a][CENT_W-1]} - {1'b0, count_reg};
            fits[a]  = !trial[a][COUNT_W] || rem_reg[a][COUNT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == AW'(NUM_REGIONS - 1))
                    begin
                        clr_addr_reg <= '0;
                        if (clr_reply_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                            state_reg <= S_IDLE;
                    end
                    else
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg    <= q_item;
                        status_reg <= q_item.status;
                        count_reg  <= '0;
                        lo_reg     <= '0;
                        hi_reg     <= '0;
                        quo_reg    <= '0;
                        unique case (q_item.kind)
                            K_ACC, K_READ: state_reg <= S_EXEC;
                            K_CLEAR:
                            begin
                                clr_reply_reg <= 1'b1;
                                state_reg     <= S_CLEAR;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_OUT;
                            end
                        endcase
                    end
                end
                S_EXEC:
                begin
                    if (cur_reg.kind == K_READ && rdata_reg.count != '0)
                    begin
                        count_reg <= rdata_reg.count;
                        lo_reg    <= rdata_reg.lo;
                        hi_reg    <= rdata_reg.hi;
                        for (int a = 0; a < 3; a++)
                        begin
                            rem_reg[a] <= rdata_reg.sum[a][SUM_W-1:CENT_W-8];
                            quo_reg[a] <= {rdata_reg.sum[a][CENT_W-9:0], 8'd0};
                        end
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (cur_reg.kind == K_READ)
                            status_reg <= ST_EMPTY;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        if (fits[a])
                            rem_reg[a] <= trial[a][COUNT_W-1:0];
                        else
                            rem_reg[a] <= {rem_reg[a][COUNT_W-2:0], quo_reg[a][CENT_W-1]};
                        quo_reg[a] <= {quo_reg[a][CENT_W-2:0], fits[a]};
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(DIV_STEPS - 1))
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        clr_reply_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign voxel_count = count_reg;
    assign box_lo      = lo_reg;
    assign box_hi      = hi_reg;
    assign cent        = quo_reg;

endmodule

// ===== design/lrs_checker.sv =====
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lrs_checker
    import lrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [STAT_W-1:0]  status,
    input  logic [COUNT_W-1:0] voxel_count,
    input  logic [COORD_W-1:0] min_x,
    input  logic [COORD_W-1:0] max_x,
    input  logic [CENT_W-1:0]  centroid_x
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result beat dropped while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> voxel_count == '0 && centroid_x == '0)
        else $error("failed result carries data");

    a_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && voxel_count != '0 |-> min_x <= max_x)
        else $error("inverted bounding box");

    a_cent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && voxel_count != '0 |->
            centroid_x >= {min_x, 8'd0} && centroid_x <= {max_x, 8'd0})
        else $error("centroid outside box");

endmodule

bind labelled_region_statistics_top lrs_checker u_lrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .voxel_count (voxel_count),
    .min_x       (min_x),
    .max_x       (max_x),
    .centroid_x  (centroid_x)
);
